// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker modules of the envelope block.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BEV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("envelope check failed");

// Consequent checked in the cycle after the antecedent.
`define BEV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("envelope check failed");

`endif

// ===== sv/bev_pkg.sv =====
// Shared types and codes for the breakpoint envelope block.
// No dependencies; used by the interfaces, the core and the checker.
`timescale 1ns / 1ps

package bev_pkg;

	localparam int LEVEL_W      = 16;
	localparam int LEN_W        = 24;
	localparam int POS_W        = 24;
	localparam int SLOPE_W      = 32;
	localparam int SAMPLE_W     = 16;
	localparam int ENV_FRAMES_W = 24;
	localparam int COUNT_W      = 5;
	localparam int INDEX_W      = 4;
	localparam int ACTION_W     = 2;
	localparam int DIV_STEPS    = 32;

	localparam logic signed [LEVEL_W-1:0] INIT_LEVEL_RESET = 16'sd4096;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_TERMINAL_MODE   = 3'd0,
		REG_ENVELOPE_SHAPE  = 3'd1,
		REG_POINT_COUNT     = 3'd2,
		REG_INITIAL_LEVEL   = 3'd3,
		REG_ENVELOPE_FRAMES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic [LEN_W-1:0]          len;
	} tbl_entry_t;

endpackage

// ===== sv/bev_ifs.sv =====
// Valid/ready channel interfaces for the envelope block: command items in,
// result items out. Depends on bev_pkg for field widths.
`timescale 1ns / 1ps

interface bev_cmd_if import bev_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [INDEX_W-1:0]         point_index;
	logic signed [LEVEL_W-1:0]  point_level;
	logic [LEN_W-1:0]           segment_frames;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, action, point_index, point_level, segment_frames,
		sample_in, input ready);
	modport sink (input valid, action, point_index, point_level, segment_frames,
		sample_in, output ready);
endinterface

interface bev_res_if import bev_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic signed [LEVEL_W-1:0]  envelope_level;
	logic                       release_done;

	modport source (output valid, sample_out, envelope_level, release_done, input ready);
	modport sink (input valid, sample_out, envelope_level, release_done, output ready);
endinterface

// ===== sv/breakpoint_envelope_vca_core.sv =====
// Breakpoint envelope generator with amplifier. Command items either load one
// breakpoint (level in Q4.12 and segment length in frames) into the table,
// rewind the envelope to frame zero, or process one audio sample. Only sample
// items produce a result item: the envelope value for the frame, the sample
// scaled by it (saturated, or the envelope alone in terminal mode) and a
// release flag once the frame count reaches envelope_frames. A sample item
// passes through the LOOK, TEST, MUL, LEVEL, AMP and EMIT states when the
// current segment's slope is already known, adds a LOOK and a TEST for each
// zero-length or finished segment it steps over, and adds the DIV and SLOPE
// states when it enters a new segment, since the slope comes from a restoring
// divider producing one bit per cycle (32 steps plus sign and saturation).
// A released frame goes straight to EMIT. The breakpoints live in a table
// memory with one write port and a registered read port; the table needs no
// clearing pass after reset, but entries read before being written return
// undefined values. Configuration goes through an APB-style port and must
// only be written while the block is idle.
// Depends on bev_pkg, bev_ifs.
`timescale 1ns / 1ps

module breakpoint_envelope_vca_core import bev_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int FRAME_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bev_cmd_if.sink     cmd,
	bev_res_if.source   res
);

	localparam int IW     = $clog2(MAX_POINTS + 1);
	localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW   = (IW > COUNT_W) ? IW : COUNT_W;
	localparam int CMP_W  = (FRAME_BITS > ENV_FRAMES_W) ? FRAME_BITS : ENV_FRAMES_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int PROD_W = POS_W + 1 + SLOPE_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_TEST,
		ST_DIV,
		ST_SLOPE,
		ST_MUL,
		ST_LEVEL,
		ST_AMP,
		ST_EMIT
	} state_t;

	// configuration registers
	logic                      terminal_q;
	logic                      shape_q;
	logic [COUNT_W-1:0]        point_count_q;
	logic signed [LEVEL_W-1:0] init_level_q;
	logic [ENV_FRAMES_W-1:0]   env_frames_q;

	// breakpoint table and its registered read port
	tbl_entry_t tbl_q [MAX_POINTS];
	tbl_entry_t rd_q;
	logic [AW-1:0] rd_addr;
	logic          tbl_we;

	// envelope state
	state_t                     state_q;
	logic [FRAME_BITS-1:0]      frame_q;
	logic [IW-1:0]              seg_idx_q;
	logic [POS_W-1:0]           pos_q;
	logic signed [LEVEL_W-1:0]  start_q;
	logic signed [SLOPE_W-1:0]  slope_q;
	logic                       slope_valid_q;

	// per-item work registers
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       release_q;
	logic signed [LEVEL_W-1:0]  level_q;
	logic [SLOPE_W-1:0]         quo_q;
	logic [LEN_W-1:0]           rem_q;
	logic [LEN_W-1:0]           div_len_q;
	logic                       div_neg_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [31:0]         amp_s1;

	// result register
	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic signed [LEVEL_W-1:0]  res_level_q;
	logic                       res_done_q;

	logic cmd_acc;
	logic cfg_wr;
	logic in_segments;
	logic pos_may_inc;
	logic released;

	logic signed [LEVEL_W:0]   diff;
	logic [LEVEL_W-1:0]        diff_mag;
	logic [LEN_W:0]            trial;
	logic                      trial_ge;
	logic signed [19:0]        amp_sh;
	logic signed [SAMPLE_W-1:0] amp_sat;

	assign pready    = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg_wr    = psel && penable && pwrite;

	assign res.valid          = res_valid_q;
	assign res.sample_out     = res_sample_q;
	assign res.envelope_level = res_level_q;
	assign res.release_done   = res_done_q;

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terminal_q    <= 1'b0;
			shape_q       <= 1'b0;
			point_count_q <= '0;
			init_level_q  <= INIT_LEVEL_RESET;
			env_frames_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_TERMINAL_MODE:   terminal_q    <= pwdata[0];
				REG_ENVELOPE_SHAPE:  shape_q       <= pwdata[0];
				REG_POINT_COUNT:     point_count_q <= pwdata[COUNT_W-1:0];
				REG_INITIAL_LEVEL:   init_level_q  <= pwdata[LEVEL_W-1:0];
				REG_ENVELOPE_FRAMES: env_frames_q  <= pwdata[ENV_FRAMES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_TERMINAL_MODE:   prdata = {31'b0, terminal_q};
			REG_ENVELOPE_SHAPE:  prdata = {31'b0, shape_q};
			REG_POINT_COUNT:     prdata = {{(32-COUNT_W){1'b0}}, point_count_q};
			REG_INITIAL_LEVEL:   prdata = {{(32-LEVEL_W){init_level_q[LEVEL_W-1]}}, init_level_q};
			REG_ENVELOPE_FRAMES: prdata = {{(32-ENV_FRAMES_W){1'b0}}, env_frames_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Breakpoint table: written only on an accepted write item (block idle),
	// read while a sample item walks the segments, so the ports never collide.
	// ---------------------------------------------------------------------
	assign tbl_we  = cmd_acc && (cmd.action == ACT_WRITE) &&
		({{(32-INDEX_W){1'b0}}, cmd.point_index} < MAX_POINTS);
	assign rd_addr = seg_idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_q[AW'(cmd.point_index)] <= '{level: cmd.point_level, len: cmd.segment_frames};
		end
		rd_q <= tbl_q[rd_addr];
	end

	// ---------------------------------------------------------------------
	// Datapath helpers
	// ---------------------------------------------------------------------
	// Segment walk stops at min(point_count, MAX_POINTS).
	assign in_segments = (CNTW'(seg_idx_q) < CNTW'(point_count_q)) &&
		(seg_idx_q < IW'(MAX_POINTS));
	assign pos_may_inc = (seg_idx_q < IW'(MAX_POINTS)) && (pos_q != '1);
	assign released    = CMP_W'(frame_q) >= CMP_W'(env_frames_q);

	always_comb begin
		diff     = {rd_q.level[LEVEL_W-1], rd_q.level} - {start_q[LEVEL_W-1], start_q};
		diff_mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
		trial    = {rem_q, quo_q[SLOPE_W-1]};
		trial_ge = trial >= {1'b0, div_len_q};
		amp_sh   = amp_s1[31:12];
		if (amp_sh > 20'sd32767) begin
			amp_sat = 16'sh7FFF;
		end else if (amp_sh < -20'sd32768) begin
			amp_sat = 16'sh8000;
		end else begin
			amp_sat = amp_sh[SAMPLE_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_q       <= '0;
			seg_idx_q     <= '0;
			pos_q         <= '0;
			start_q       <= INIT_LEVEL_RESET;
			slope_q       <= '0;
			slope_valid_q <= 1'b0;
			sample_q      <= '0;
			release_q     <= 1'b0;
			level_q       <= '0;
			quo_q         <= '0;
			rem_q         <= '0;
			div_len_q     <= '0;
			div_neg_q     <= 1'b0;
			div_cnt_q     <= '0;
			prod_s1       <= '0;
			amp_s1        <= '0;
			res_valid_q   <= 1'b0;
			res_sample_q  <= '0;
			res_level_q   <= '0;
			res_done_q    <= 1'b0;
		end else begin
			// drop the result once taken; EMIT reloads it on its own
			if (res_valid_q && res.ready && (state_q != ST_EMIT)) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd.action)
							ACT_RESTART: begin
								frame_q       <= '0;
								seg_idx_q     <= '0;
								pos_q         <= '0;
								start_q       <= init_level_q;
								slope_q       <= '0;
								slope_valid_q <= 1'b0;
							end
							ACT_SAMPLE: begin
								sample_q  <= cmd.sample_in;
								release_q <= released;
								// frame counter saturates at its all-ones value
								if (!(&frame_q)) begin
									frame_q <= frame_q + 1'b1;
								end
								if (released) begin
									state_q <= ST_EMIT;
								end else if (shape_q) begin
									level_q <= init_level_q;
									state_q <= ST_AMP;
								end else begin
									state_q <= ST_LOOK;
								end
							end
							default: ;
						endcase
					end
				end

				ST_LOOK: begin
					// table read for seg_idx_q is issued this cycle
					if (in_segments) begin
						state_q <= ST_TEST;
					end else begin
						// past the last segment: hold the last start level
						level_q <= start_q;
						if (pos_may_inc) begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= ST_AMP;
					end
				end

				ST_TEST: begin
					if (pos_q < rd_q.len) begin
						if (slope_valid_q) begin
							state_q <= ST_MUL;
						end else begin
							// slope = ((next - start) << 16) / len, by magnitude
							div_neg_q <= diff[LEVEL_W];
							quo_q     <= {diff_mag, 16'b0};
							rem_q     <= '0;
							div_len_q <= rd_q.len;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end
					end else begin
						// segment finished or zero length: jump to its level
						start_q       <= rd_q.level;
						seg_idx_q     <= seg_idx_q + 1'b1;
						pos_q         <= '0;
						slope_valid_q <= 1'b0;
						state_q       <= ST_LOOK;
					end
				end

				ST_DIV: begin
					if (trial_ge) begin
						rem_q <= LEN_W'(trial - {1'b0, div_len_q});
					end else begin
						rem_q <= trial[LEN_W-1:0];
					end
					quo_q     <= {quo_q[SLOPE_W-2:0], trial_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_SLOPE;
					end
				end

				ST_SLOPE: begin
					// apply sign, saturate to signed 32 bits
					if (!div_neg_q) begin
						slope_q <= quo_q[SLOPE_W-1] ? 32'sh7FFFFFFF : $signed(quo_q);
					end else if (quo_q > 32'h80000000) begin
						slope_q <= 32'sh80000000;
					end else begin
						slope_q <= -$signed(quo_q);
					end
					slope_valid_q <= 1'b1;
					state_q       <= ST_MUL;
				end

				ST_MUL: begin
					prod_s1 <= $signed({1'b0, pos_q}) * slope_q;
					state_q <= ST_LEVEL;
				end

				ST_LEVEL: begin
					// floor(pos * slope / 65536); only the low 16 bits survive
					level_q <= start_q + prod_s1[LEVEL_W+15:16];
					if (pos_may_inc) begin
						pos_q <= pos_q + 1'b1;
					end
					state_q <= ST_AMP;
				end

				ST_AMP: begin
					amp_s1  <= sample_q * level_q;
					state_q <= ST_EMIT;
				end

				ST_EMIT: begin
					// hold until the result register is free
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						if (release_q) begin
							res_sample_q <= '0;
							res_level_q  <= '0;
							res_done_q   <= 1'b1;
						end else begin
							res_sample_q <= terminal_q ? level_q : amp_sat;
							res_level_q  <= level_q;
							res_done_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/bev_checker.sv =====
// Port-level checks for the envelope core, attached by the bind below.
// Depends on bev_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bev_checker import bev_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic [ACTION_W-1:0]        cmd_action,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic signed [SAMPLE_W-1:0] res_sample_out,
	input logic signed [LEVEL_W-1:0]  res_envelope_level,
	input logic                       res_release_done
);

	logic                          cmd_acc;
	logic [SAMPLE_W+LEVEL_W:0]     res_payload;

	assign cmd_acc     = cmd_valid && cmd_ready;
	assign res_payload = {res_sample_out, res_envelope_level, res_release_done};

	// a stalled result holds
	`BEV_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload))

	// a released frame carries zero output and zero envelope
	`BEV_ASSERT_NOW(a_release_zero, res_valid && res_release_done, res_payload[SAMPLE_W+LEVEL_W:1] == '0)

	// a sample item keeps the block busy for at least the next cycle
	`BEV_ASSERT_NEXT(a_sample_busy, cmd_acc && cmd_action == ACT_SAMPLE, !cmd_ready)

	// write, restart and unused items raise no result
	`BEV_ASSERT_NEXT(a_no_spurious, cmd_acc && cmd_action != ACT_SAMPLE && !res_valid, !res_valid)

endmodule

bind breakpoint_envelope_vca_core bev_checker u_bev_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.cmd_action         (cmd.action),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_sample_out     (res.sample_out),
	.res_envelope_level (res.envelope_level),
	.res_release_done   (res.release_done)
);
